@@ src/apq_pkg.sv @@
// Shared types and codes for the aging priority queue.
`timescale 1ns / 1ps

package apq_pkg;

    localparam int ID_W   = 8;
    localparam int PRIO_W = 4;
    localparam int FILL_W = 5;

    localparam logic [1:0] MODE_INSERT   = 2'd0;
    localparam logic [1:0] MODE_RETRIEVE = 2'd1;
    localparam logic [1:0] MODE_CLOSE    = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_CLOSED = 2'd3;

    localparam logic [PRIO_W-1:0] PRIO_FLOOR = 4'd1;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ID_W-1:0]   req_id;
        logic [PRIO_W-1:0] req_priority;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   out_id;
        logic [FILL_W-1:0] fill_count;
        logic              closed_flag;
    } rsp_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } entry_t;

endpackage

@@ src/apq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module apq_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/apq_ctrl.sv @@
// Sequencer that walks the entry store for insert, retrieve and ageing.
`timescale 1ns / 1ps

module apq_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    input  apq_pkg::req_t            req,
    output logic                     busy,
    output logic                     res_valid,
    output apq_pkg::rsp_t            res,
    input  logic                     res_ack,
    output logic                     mem_we,
    output logic [$clog2(DEPTH)-1:0] mem_waddr,
    output apq_pkg::entry_t          mem_wdata,
    output logic [$clog2(DEPTH)-1:0] mem_raddr,
    input  apq_pkg::entry_t          mem_rdata
);

    import apq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_INS_CMP  = 3'd1;
    localparam logic [2:0] S_INS_PUT  = 3'd2;
    localparam logic [2:0] S_RET_HEAD = 3'd3;
    localparam logic [2:0] S_RET_AGE  = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    logic [2:0]       state_reg,  state_next;
    logic [PTR_W-1:0] head_reg,   head_next;
    logic [PTR_W-1:0] tail_reg,   tail_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             closed_reg, closed_next;
    logic [PTR_W-1:0] pos_reg,    pos_next;
    logic [CNT_W-1:0] left_reg,   left_next;
    entry_t           item_reg,   item_next;
    logic [1:0]       status_reg, status_next;
    logic [ID_W-1:0]  id_reg,     id_next;

    logic [PTR_W-1:0] prev_pos;
    entry_t           aged;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
    endfunction

    assign prev_pos  = ptr_dec(pos_reg);
    assign aged.id   = mem_rdata.id;
    assign aged.prio = (mem_rdata.prio > PRIO_FLOOR) ? mem_rdata.prio - 1'b1 : mem_rdata.prio;

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        closed_next = closed_reg;
        pos_next    = pos_reg;
        left_next   = left_reg;
        item_next   = item_reg;
        status_next = status_reg;
        id_next     = id_reg;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg;
        mem_wdata   = item_reg;
        mem_raddr   = prev_pos;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next.id   = req.req_id;
                    item_next.prio = req.req_priority;
                    status_next    = ST_OK;
                    id_next        = '0;
                    state_next     = S_DONE;
                    unique case (req.mode)
                        MODE_INSERT:
                        begin
                            if (closed_reg)
                            begin
                                status_next = ST_CLOSED;
                            end
                            else if (count_reg == CNT_W'(DEPTH))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                pos_next  = tail_reg;
                                mem_raddr = ptr_dec(tail_reg);
                                state_next = (count_reg == '0) ? S_INS_PUT : S_INS_CMP;
                            end
                        end
                        MODE_RETRIEVE:
                        begin
                            if (closed_reg)
                            begin
                                status_next = ST_CLOSED;
                            end
                            else if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_raddr  = head_reg;
                                state_next = S_RET_HEAD;
                            end
                        end
                        MODE_CLOSE:
                        begin
                            if (closed_reg)
                            begin
                                status_next = ST_CLOSED;
                            end
                            else
                            begin
                                closed_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_INS_CMP:
            begin
                // rdata holds the entry just ahead of pos
                if (mem_rdata.prio > item_reg.prio)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata;
                    pos_next  = prev_pos;
                    mem_raddr = ptr_dec(prev_pos);
                    if (prev_pos == head_reg)
                    begin
                        state_next = S_INS_PUT;
                    end
                end
                else
                begin
                    mem_we     = 1'b1;
                    tail_next  = ptr_inc(tail_reg);
                    count_next = count_reg + 1'b1;
                    state_next = S_DONE;
                end
            end
            S_INS_PUT:
            begin
                mem_we     = 1'b1;
                tail_next  = ptr_inc(tail_reg);
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end
            S_RET_HEAD:
            begin
                id_next    = mem_rdata.id;
                head_next  = ptr_inc(head_reg);
                count_next = count_reg - 1'b1;
                if (count_reg == CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    mem_raddr  = ptr_inc(head_reg);
                    pos_next   = ptr_inc(head_reg);
                    left_next  = count_reg - 1'b1;
                    state_next = S_RET_AGE;
                end
            end
            S_RET_AGE:
            begin
                // write back the aged entry while the next one is read
                mem_we    = 1'b1;
                mem_wdata = aged;
                mem_raddr = ptr_inc(pos_reg);
                if (left_reg == CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    pos_next  = ptr_inc(pos_reg);
                    left_next = left_reg - 1'b1;
                end
            end
            S_DONE:
            begin
                if (res_ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            closed_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            closed_reg <= closed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        left_reg   <= left_next;
        item_reg   <= item_next;
        status_reg <= status_next;
        id_reg     <= id_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res.status      = status_reg;
        res.out_id      = id_reg;
        res.fill_count  = FILL_W'(count_reg);
        res.closed_flag = closed_reg;
    end

endmodule

@@ src/aging_priority_queue.sv @@
// Aging priority queue: one item in work at a time, walked through a single entry RAM.
// A close, a reject or an unused mode goes straight to the result beat; an insert moves
// each entry of greater priority value one place toward the tail, then writes the new
// item, and a retrieve reads the head, then ages every remaining entry in turn.
// The next item is taken the cycle after its result registers; while the output beat
// stalls, the result waits. Reset clears head, tail, count and the closed flag;
// the entry RAM is not cleared.
`timescale 1ns / 1ps

module aging_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  apq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output apq_pkg::rsp_t rsp
);

    import apq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    logic             busy;
    logic             res_valid;
    rsp_t             res;
    logic             res_ack;
    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic [PTR_W-1:0] mem_raddr;
    entry_t           mem_rdata;

    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg;

    apq_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .busy      (busy),
        .res_valid (res_valid),
        .res       (res),
        .res_ack   (res_ack),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    apq_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register frees when empty or when its beat is taken
    assign res_ack = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (res_valid && res_ack)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ack)
        begin
            rsp_reg <= res;
        end
    end

    assign req_stall = busy;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ src/apq_checker.sv @@
// Port-level checks for the aging priority queue, bound to the top level.
`timescale 1ns / 1ps

module apq_checker #(
    parameter int DEPTH = 16
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input apq_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input apq_pkg::rsp_t rsp
);

    import apq_pkg::*;

    // hold a stalled result beat
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result beat changed");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second item taken while one is in work");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (int'(rsp.fill_count) <= DEPTH))
        else $error("fill count above depth");

    a_id_zero_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |-> (rsp.out_id == '0))
        else $error("id returned with a reject status");

endmodule

bind aging_priority_queue apq_checker #(
    .DEPTH(DEPTH)
) u_apq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
